### rtl/txcw_pkg.sv
// Package for the text console writer: controller states, opcodes and fixed codes.
// Used by text_console_writer_core.sv.

package txcw_pkg;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCROLL,
      ST_FILL,
      ST_DONE
   } state_type;

   // Operation codes carried in the request beat.
   localparam logic [2:0] OP_PUT_CHAR     = 3'd0;
   localparam logic [2:0] OP_BACKSPACE    = 3'd1;
   localparam logic [2:0] OP_CLEAR_SCREEN = 3'd2;
   localparam logic [2:0] OP_CLEAR_ROW    = 3'd3;
   localparam logic [2:0] OP_WRITE_CELL   = 3'd4;
   localparam logic [2:0] OP_READ_CELL    = 3'd5;

   localparam logic [7:0] NEWLINE_CODE = 8'h0A;
   localparam logic [7:0] BLANK_CODE   = 8'h20;

   // Register file: one register, word index taken from paddr[2].
   localparam int         CSR_ADDR_W         = 3;
   localparam logic       CSR_TEXT_ATTR_IDX  = 1'b0;
   localparam logic [7:0] TEXT_ATTR_RESET    = 8'h0F;

   // Field widths of the request and response beats.
   localparam int ROW_OUT_W = 5;
   localparam int COL_OUT_W = 7;

endpackage

### rtl/text_console_writer_core.sv
// Text console writer: cursor engine over a single-port-write cell memory.
// Depends on txcw_pkg.sv.
//
// Channel   Direction  Signals                          Content
// req       in         req_tvalid/tready/tdata[31:0]    one operation per beat
// rsp       out        rsp_tvalid/tready/tdata[31:0]    cursor and read cell per beat
// csr       in         APB psel/penable/pwrite/paddr    text_attribute at address 0
//
// Put char, backspace, write cell and read cell pass through the accept cycle and
// the cycle that loads the response register. Clear row writes COLUMNS cells,
// clear screen ROWS*COLUMNS, and a newline or a wrap on the last row
// (ROWS-STATUS_ROWS)*COLUMNS, each through the one write port of the cell memory.
// After reset all ROWS*COLUMNS cells are swept to zero with req_tready low.
// A response that is not taken holds the block in its final cycle; the next request
// may still be accepted while that response waits.

module text_console_writer_core #(
   parameter int COLUMNS     = 80,
   parameter int ROWS        = 25,
   parameter int STATUS_ROWS = 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // opcode[2:0], char_code[10:3], row_sel[15:11], col_sel[22:16],
   // fore_colour[26:23], back_colour[30:27], zero[31]
   input  logic [31:0]                     req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cursor_row_out[4:0], cursor_col_out[11:5], cell_char[19:12],
   // cell_attr[27:20], zero[31:28]
   output logic [31:0]                     rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [txcw_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int DEPTH = ROWS * COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS + 1);
   localparam int SCROLL_CELLS = (ROWS - 1 - STATUS_ROWS) * COLUMNS;

   localparam logic [AW-1:0] COLS_A        = AW'(COLUMNS);
   localparam logic [AW-1:0] LAST_ADDR     = AW'(DEPTH - 1);
   localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
   localparam logic [AW-1:0] SCR_FIRST     = AW'(STATUS_ROWS * COLUMNS);
   localparam logic [AW-1:0] SCR_LAST      = AW'((ROWS - 1) * COLUMNS - 1);
   localparam logic [AW-1:0] SCR_SRC0      = AW'((STATUS_ROWS + 1) * COLUMNS);
   localparam logic [AW-1:0] SCR_OFFSET    = AW'(COLUMNS + 1);
   localparam logic [RW-1:0] LAST_ROW      = RW'(ROWS - 1);
   localparam logic [RW-1:0] HOME_ROW      = RW'(STATUS_ROWS);
   localparam logic [CW-1:0] FULL_COL      = CW'(COLUMNS);

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
      cell_addr = AW'(r) * COLS_A + AW'(c);
   endfunction

   // Request fields.
   logic [2:0] req_opcode;
   logic [7:0] req_char_code;
   logic [4:0] req_row_sel;
   logic [6:0] req_col_sel;
   logic [7:0] req_attr;

   assign req_opcode    = req_tdata[2:0];
   assign req_char_code = req_tdata[10:3];
   assign req_row_sel   = req_tdata[15:11];
   assign req_col_sel   = req_tdata[22:16];
   assign req_attr      = {req_tdata[30:27], req_tdata[26:23]};

   // Cell memory.
   logic [15:0]   cell_mem [DEPTH];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [15:0]   mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [15:0]   mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= cell_mem[mem_raddr];
      end
   end

   // Control and datapath registers.
   txcw_pkg::state_type state_ff, state_in;
   logic [RW-1:0] cur_row_ff, cur_row_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [AW-1:0] fill_addr_ff, fill_addr_in;
   logic [AW-1:0] fill_end_ff, fill_end_in;
   logic [15:0]   fill_cell_ff, fill_cell_in;
   logic [7:0]    char_ff, char_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] scr_addr_ff, scr_addr_in;
   logic          rd_ok_ff, rd_ok_in;
   logic [7:0]    text_attr_ff, text_attr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [4:0]    rsp_row_ff, rsp_row_in;
   logic [6:0]    rsp_col_ff, rsp_col_in;
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic [7:0]    rsp_attr_ff, rsp_attr_in;

   logic req_accept;
   logic row_in_range;
   logic cell_in_range;
   logic is_newline;
   logic line_full;
   logic csr_write;

   assign req_tready    = (state_ff == txcw_pkg::ST_IDLE);
   assign req_accept    = req_tvalid && req_tready;
   assign row_in_range  = (32'(req_row_sel) < 32'(ROWS));
   assign cell_in_range = row_in_range && (32'(req_col_sel) < 32'(COLUMNS));
   assign is_newline    = (req_char_code == txcw_pkg::NEWLINE_CODE);
   assign line_full     = (cur_col_ff == FULL_COL);

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == txcw_pkg::CSR_TEXT_ATTR_IDX) ?
                       {24'd0, text_attr_ff} : 32'd0;

   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      fill_addr_in = fill_addr_ff;
      fill_end_in  = fill_end_ff;
      fill_cell_in = fill_cell_ff;
      char_in      = char_ff;
      pend_in      = pend_ff;
      scr_addr_in  = scr_addr_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      text_attr_in = text_attr_ff;
      mem_we       = 1'b0;
      mem_waddr    = fill_addr_ff;
      mem_wdata    = fill_cell_ff;
      mem_re       = 1'b0;
      mem_raddr    = SCR_SRC0;

      if (csr_write && (csr_paddr[2] == txcw_pkg::CSR_TEXT_ATTR_IDX)) begin
         text_attr_in = csr_pwdata[7:0];
      end

      case (state_ff)
         txcw_pkg::ST_CLEAR: begin
            mem_we       = 1'b1;
            mem_waddr    = fill_addr_ff;
            mem_wdata    = 16'd0;
            fill_addr_in = fill_addr_ff + 1'b1;
            if (fill_addr_ff == LAST_ADDR) begin
               state_in = txcw_pkg::ST_IDLE;
            end
         end

         txcw_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = txcw_pkg::ST_DONE;
               rd_ok_in = 1'b0;
               pend_in  = 1'b0;
               char_in  = req_char_code;
               case (req_opcode)
                  txcw_pkg::OP_PUT_CHAR: begin
                     if (!is_newline && !line_full) begin
                        mem_we     = 1'b1;
                        mem_waddr  = cell_addr(cur_row_ff, cur_col_ff);
                        mem_wdata  = {text_attr_ff, req_char_code};
                        cur_col_in = CW'(cur_col_ff + 1'b1);
                     end else if (cur_row_ff != LAST_ROW) begin
                        // Move down a row; a wrapped character lands in column zero.
                        cur_row_in = RW'(cur_row_ff + 1'b1);
                        cur_col_in = is_newline ? CW'(0) : CW'(1);
                        if (!is_newline) begin
                           mem_we    = 1'b1;
                           mem_waddr = cell_addr(RW'(cur_row_ff + 1'b1), CW'(0));
                           mem_wdata = {text_attr_ff, req_char_code};
                        end
                     end else begin
                        // Scroll the body up, then blank the last row. A wrapped
                        // character goes into the first cell of that blank row.
                        cur_col_in   = is_newline ? CW'(0) : CW'(1);
                        pend_in      = !is_newline;
                        fill_addr_in = LAST_ROW_BASE;
                        fill_end_in  = LAST_ADDR;
                        fill_cell_in = {text_attr_ff, txcw_pkg::BLANK_CODE};
                        if (SCROLL_CELLS > 0) begin
                           mem_re      = 1'b1;
                           mem_raddr   = SCR_SRC0;
                           scr_addr_in = SCR_FIRST;
                           state_in    = txcw_pkg::ST_SCROLL;
                        end else begin
                           state_in = txcw_pkg::ST_FILL;
                        end
                     end
                  end

                  txcw_pkg::OP_BACKSPACE: begin
                     if (cur_col_ff != CW'(0)) begin
                        cur_col_in = CW'(cur_col_ff - 1'b1);
                        mem_we     = 1'b1;
                        mem_waddr  = cell_addr(cur_row_ff, CW'(cur_col_ff - 1'b1));
                        mem_wdata  = {text_attr_ff, txcw_pkg::BLANK_CODE};
                     end
                  end

                  txcw_pkg::OP_CLEAR_SCREEN: begin
                     cur_row_in   = HOME_ROW;
                     cur_col_in   = CW'(0);
                     fill_addr_in = AW'(0);
                     fill_end_in  = LAST_ADDR;
                     fill_cell_in = {text_attr_ff, txcw_pkg::BLANK_CODE};
                     state_in     = txcw_pkg::ST_FILL;
                  end

                  txcw_pkg::OP_CLEAR_ROW: begin
                     if (row_in_range) begin
                        fill_addr_in = cell_addr(RW'(req_row_sel), CW'(0));
                        fill_end_in  = AW'(cell_addr(RW'(req_row_sel), CW'(0)) + COLS_A - 1'b1);
                        fill_cell_in = {req_attr, txcw_pkg::BLANK_CODE};
                        state_in     = txcw_pkg::ST_FILL;
                     end
                  end

                  txcw_pkg::OP_WRITE_CELL: begin
                     if (cell_in_range) begin
                        mem_we    = 1'b1;
                        mem_waddr = cell_addr(RW'(req_row_sel), CW'(req_col_sel));
                        mem_wdata = {req_attr, req_char_code};
                     end
                  end

                  txcw_pkg::OP_READ_CELL: begin
                     if (cell_in_range) begin
                        mem_re    = 1'b1;
                        mem_raddr = cell_addr(RW'(req_row_sel), CW'(req_col_sel));
                        rd_ok_in  = 1'b1;
                     end
                  end

                  default: begin
                  end
               endcase
            end
         end

         txcw_pkg::ST_SCROLL: begin
            // Each cycle writes the cell read in the cycle before, taken from one row below.
            mem_we      = 1'b1;
            mem_waddr   = scr_addr_ff;
            mem_wdata   = mem_rdata_ff;
            scr_addr_in = scr_addr_ff + 1'b1;
            if (scr_addr_ff == SCR_LAST) begin
               state_in = txcw_pkg::ST_FILL;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = scr_addr_ff + SCR_OFFSET;
            end
         end

         txcw_pkg::ST_FILL: begin
            mem_we       = 1'b1;
            mem_waddr    = fill_addr_ff;
            mem_wdata    = pend_ff ? {fill_cell_ff[15:8], char_ff} : fill_cell_ff;
            pend_in      = 1'b0;
            fill_addr_in = fill_addr_ff + 1'b1;
            if (fill_addr_ff == fill_end_ff) begin
               state_in = txcw_pkg::ST_DONE;
            end
         end

         txcw_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = txcw_pkg::ROW_OUT_W'(cur_row_ff);
               rsp_col_in   = txcw_pkg::COL_OUT_W'(cur_col_ff);
               rsp_char_in  = rd_ok_ff ? mem_rdata_ff[7:0] : 8'd0;
               rsp_attr_in  = rd_ok_ff ? mem_rdata_ff[15:8] : 8'd0;
               state_in     = txcw_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = txcw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= txcw_pkg::ST_CLEAR;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         fill_addr_ff <= '0;
         pend_ff      <= 1'b0;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         text_attr_ff <= txcw_pkg::TEXT_ATTR_RESET;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         fill_addr_ff <= fill_addr_in;
         pend_ff      <= pend_in;
         rd_ok_ff     <= rd_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         text_attr_ff <= text_attr_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_end_ff  <= fill_end_in;
      fill_cell_ff <= fill_cell_in;
      char_ff      <= char_in;
      scr_addr_ff  <= scr_addr_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_attr_ff  <= rsp_attr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_attr_ff, rsp_char_ff, rsp_col_ff, rsp_row_ff};

endmodule

### rtl/txcw_checker.sv
// Port-level checks for text_console_writer_core, attached by the bind below.
// Depends on text_console_writer_core.sv.

module txcw_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // A held response beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // Every operation keeps the engine busy, so no two requests are accepted back to back.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted on two consecutive cycles");

   // The reported cursor row lies on the screen.
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (ROWS > 32) || (32'(rsp_tdata[4:0]) < 32'(ROWS)))
      else $error("cursor row beyond the last row");

   // The reported cursor column never passes the line-full position.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (COLUMNS > 127) || (32'(rsp_tdata[11:5]) <= 32'(COLUMNS)))
      else $error("cursor column beyond line-full position");

endmodule

bind text_console_writer_core txcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_txcw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
